FILE: rtl/stlru_pkg.sv
// ----------------------------------------------------------------------------
// stlru_pkg
// Shared types, codes and helpers of the set-associative tag store.
// ----------------------------------------------------------------------------
package stlru_pkg;

    localparam int AGE_W     = 3;
    localparam int WAY_IDX_W = 4;
    localparam int SLOT_W    = 8;

    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_FILL   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic                 hit;
        logic                 wr;
        logic [WAY_IDX_W-1:0] way;
    } upd_res_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a < AGE_MAX) ? a + 1'b1 : AGE_MAX;
    endfunction

endpackage

FILE: rtl/stlru_row_upd.sv
// ----------------------------------------------------------------------------
// stlru_row_upd
// Row update of one set: hit way, victim choice and new age/valid/tag row.
// ----------------------------------------------------------------------------
module stlru_row_upd import stlru_pkg::*; #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 52
) (
    input  op_t                                 op,
    input  logic [TAG_W-1:0]                    tag_in,
    input  logic [WAYS-1:0]                     match,
    input  logic [WAYS*(1+AGE_W+TAG_W)-1:0]     row_in,
    output logic [WAYS*(1+AGE_W+TAG_W)-1:0]     row_out,
    output upd_res_t                            res
);

    localparam int ENT_W  = 1 + AGE_W + TAG_W;
    localparam int WAY_AW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic                  valid [WAYS];
    logic [AGE_W-1:0]      age   [WAYS];
    logic [TAG_W-1:0]      tag   [WAYS];
    logic                  hit_any;
    logic [WAY_AW-1:0]     fway;
    logic [WAY_AW-1:0]     vway;
    logic [AGE_W-1:0]      fage;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            {valid[w], age[w], tag[w]} = row_in[w*ENT_W +: ENT_W];
        end
    end

    always_comb begin
        logic             stop;
        logic [AGE_W-1:0] vage;
        hit_any = 1'b0;
        fway    = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (valid[w] && match[w]) begin
                hit_any = 1'b1;
                fway    = WAY_AW'(w);
            end
        end
        fage = age[fway];
        stop = 1'b0;
        vage = '0;
        vway = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!stop) begin
                if (!valid[w]) begin
                    vway = WAY_AW'(w);
                    stop = 1'b1;
                end else if (age[w] >= vage) begin
                    vage = age[w];
                    vway = WAY_AW'(w);
                end
            end
        end
    end

    always_comb begin
        logic             nv;
        logic [AGE_W-1:0] na;
        logic [TAG_W-1:0] nt;
        for (int w = 0; w < WAYS; w++) begin
            nv = valid[w];
            na = age[w];
            nt = tag[w];
            if (op == OP_FILL) begin
                if (WAY_AW'(w) == vway) begin
                    nv = 1'b1;
                    na = '0;
                    nt = tag_in;
                end else begin
                    na = age_inc(age[w]);
                end
            end else if (hit_any) begin
                if (WAY_AW'(w) == fway) begin
                    na = '0;
                end else if (age[w] < fage) begin
                    na = age_inc(age[w]);
                end
            end
            row_out[w*ENT_W +: ENT_W] = {nv, na, nt};
        end
    end

    always_comb begin
        res.hit = (op == OP_LOOKUP) && hit_any;
        res.wr  = (op == OP_FILL) || hit_any;
        res.way = (op == OP_FILL) ? WAY_IDX_W'(vway) : WAY_IDX_W'(fway);
    end

endmodule

FILE: rtl/set_assoc_tag_store_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_store_lru
// Tag directory of a set-associative cache with per-line age counters (LRU).
// ----------------------------------------------------------------------------
// One set is held per row of a single-port-write, registered-read memory:
// valid, 3-bit age and tag for every way. The row is read into a register
// when a beat is accepted, the ways are compared in parallel in ST_EVAL and
// the match is registered, and in ST_UPD the row is updated, written back
// and the result loaded. One item is in flight at a time, bound by the
// read-compare-write loop on the row memory, and the next beat is taken in
// the cycle after the result is loaded. The update stage holds while the
// previous result beat is still waiting on m_tready. After reset a clearing
// pass writes one row per cycle over all 2^floor(log2(SETS)) rows (64 at the
// default size) before the first beat is taken. A lookup hit returns hit=1 and
// the slot set*WAYS+way; a miss returns zeros; a fill returns hit=0 and the
// slot of the replaced way. Slots are kept to their low 8 bits.
module set_assoc_tag_store_lru import stlru_pkg::*; #(
    parameter int LINE_BYTES = 64,
    parameter int WAYS       = 4,
    parameter int SETS       = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] byte address (line offset bits ignored)
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] hit, [8:1] line_slot, [15:9] zero
);

    localparam int OFF_BITS = $clog2(LINE_BYTES + 1) - 1;
    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int SET_AW   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int ROWS     = 1 << SET_BITS;
    localparam int TAG_LSB  = OFF_BITS + SET_BITS;
    localparam int TAG_W    = 64 - TAG_LSB;
    localparam int ENT_W    = 1 + AGE_W + TAG_W;
    localparam int ROW_W    = WAYS * ENT_W;
    localparam int SLOT_FW  = SET_AW + 5;

    localparam logic [SET_AW-1:0] SET_MASK = SET_AW'((1 << SET_BITS) - 1);
    localparam logic [SET_AW-1:0] LAST_ROW = SET_AW'(ROWS - 1);

    logic [ROW_W-1:0]   row_mem [ROWS];
    logic [ROW_W-1:0]   rdata_reg;

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [SET_AW-1:0]  set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [WAYS-1:0]    match_reg, match_next;
    logic [SET_AW-1:0]  clr_cnt_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;

    logic [SET_AW-1:0]  in_set;
    logic [TAG_W-1:0]   in_tag;
    logic               accept;
    logic               out_free;
    logic               wr_en;
    logic               out_load;
    logic [SET_AW-1:0]  wr_addr;
    logic [ROW_W-1:0]   wr_data;
    logic [ROW_W-1:0]   new_row;
    upd_res_t           res;
    logic [SLOT_FW-1:0] slot_full;
    logic [SLOT_W-1:0]  slot;

    assign in_set   = SET_AW'(s_tdata >> OFF_BITS) & SET_MASK;
    assign in_tag   = TAG_W'(s_tdata >> TAG_LSB);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match_next[w] = (rdata_reg[w*ENT_W +: TAG_W] == tag_reg);
        end
    end

    stlru_row_upd #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_row_upd (
        .op      (op_reg),
        .tag_in  (tag_reg),
        .match   (match_reg),
        .row_in  (rdata_reg),
        .row_out (new_row),
        .res     (res)
    );

    assign slot_full = SLOT_FW'(set_reg) * SLOT_FW'(WAYS) + SLOT_FW'(res.way);
    assign slot      = ((op_reg == OP_FILL) || res.hit) ? SLOT_W'(slot_full) : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == LAST_ROW) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_UPD;
            ST_UPD:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = set_reg;
        wr_data  = new_row;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_IDLE:  s_tready = 1'b1;
            ST_EVAL:  ;
            ST_UPD: begin
                out_load = out_free;
                wr_en    = out_free && res.wr;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rdata_reg <= row_mem[in_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_tuser[0]);
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
        if (state_reg == ST_EVAL) begin
            match_reg <= match_next;
        end
        if (out_load) begin
            m_tdata_reg <= {7'b0, slot, res.hit};
        end
    end

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("beat taken during clearing pass");

    a_accept_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted beat did not advance to compare");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg)
        else $error("result beat lost");

    a_fill_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_UPD) && (op_reg == OP_FILL)) |-> (!res.hit && res.wr))
        else $error("fill reported as hit or skipped write");

    a_way_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (int'(res.way) < WAYS))
        else $error("selected way out of range");

endmodule
